### design/i2d_pkg.sv
// Package for the binary to decimal digit converter with round-half-even.
// Holds the digit constants, widths and the sequencer state type.
// No dependencies; used by every file of the design.
package i2d_pkg;

    localparam int NUM_DIGITS        = 10;
    localparam int DIGIT_W           = 4;
    localparam int BCD_W             = NUM_DIGITS * DIGIT_W;
    localparam int KEEP_W            = 4;
    localparam int DATA_IN_W         = 32;
    localparam int DATA_OUT_W        = BCD_W + 2 * KEEP_W;
    localparam int VALUE_WIDTH_DEF   = 32;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [KEEP_W-1:0]  index_t;

    localparam digit_t DIGIT_ZERO = 4'd0;
    localparam digit_t DIGIT_ONE  = 4'd1;
    localparam digit_t DIGIT_FIVE = 4'd5;
    localparam digit_t DIGIT_NINE = 4'd9;
    localparam digit_t DABBLE_ADJ = 4'd3;

    localparam index_t LAST_INDEX = index_t'(NUM_DIGITS - 1);
    localparam index_t FULL_LEN   = index_t'(NUM_DIGITS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD,
        ST_NORM,
        ST_DEC1,
        ST_DEC2,
        ST_INC,
        ST_TRIM,
        ST_DONE
    } state_t;

endpackage

### design/i2d_dabble_step.sv
// One shift-and-add-3 step of the binary to BCD conversion.
// Depends on i2d_pkg for the digit count and digit constants.
module i2d_dabble_step (
    input  logic [i2d_pkg::BCD_W-1:0] bcd_in,
    input  logic                      bit_in,
    output logic [i2d_pkg::BCD_W-1:0] bcd_out
);

    logic [i2d_pkg::BCD_W-1:0] adj;

    always_comb begin
        for (int i = 0; i < i2d_pkg::NUM_DIGITS; i++) begin
            if (bcd_in[i*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W] >= i2d_pkg::DIGIT_FIVE) begin
                adj[i*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W] =
                    bcd_in[i*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W] + i2d_pkg::DABBLE_ADJ;
            end else begin
                adj[i*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W] =
                    bcd_in[i*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W];
            end
        end
        bcd_out = {adj[i2d_pkg::BCD_W-2:0], bit_in};
    end

endmodule

### design/int_to_decimal_digits_round_half_even_unit.sv
// Top level of the binary to decimal digit converter with round-half-even.
// Depends on i2d_pkg and i2d_dabble_step.
// The sequencer runs the shift-and-add-3 conversion, loads the digits, strips leading
// zeros, makes the round-half-even decision and propagates any carry when rounding is
// needed, else trims trailing zeros, and posts the result once the output register is free.
// A new request is taken only when the sequencer is back in idle; s_tready is high only when idle.
// Reset: synchronous, active low; clears the sequencer, the output valid and the register.
module int_to_decimal_digits_round_half_even_unit #(
    parameter int VALUE_WIDTH = i2d_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [i2d_pkg::KEEP_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [i2d_pkg::DATA_IN_W-1:0]    s_tdata,   // value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [i2d_pkg::DATA_OUT_W-1:0]   m_tdata    // digits_bcd, digit_count, decimal_position
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    i2d_pkg::state_t              state_reg, state_next;
    logic [VALUE_WIDTH-1:0]       mag_reg, mag_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [i2d_pkg::BCD_W-1:0]    bcd_reg, bcd_next, bcd_step;
    i2d_pkg::digit_t              dig_reg [i2d_pkg::NUM_DIGITS];
    i2d_pkg::digit_t              dig_next [i2d_pkg::NUM_DIGITS];
    i2d_pkg::index_t              len_reg, len_next;
    i2d_pkg::index_t              pos_reg, pos_next;
    i2d_pkg::index_t              ptr_reg, ptr_next;
    i2d_pkg::index_t              keep_reg, keep_next;
    logic                         up_reg, up_next;
    logic                         half_reg, half_next;
    logic                         m_valid_reg, m_valid_next;
    logic [i2d_pkg::DATA_OUT_W-1:0] m_data_reg, m_data_next;

    logic [VALUE_WIDTH-1:0]       raw;
    i2d_pkg::digit_t              rd;
    logic                         rest_nz;
    logic                         sticky;
    logic [i2d_pkg::BCD_W-1:0]    packed_bcd;

    i2d_dabble_step u_step (
        .bcd_in  (bcd_reg),
        .bit_in  (mag_reg[VALUE_WIDTH-1]),
        .bcd_out (bcd_step)
    );

    assign raw      = s_tdata[VALUE_WIDTH-1:0];
    assign s_tready = (state_reg == i2d_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        rd      = dig_reg[ptr_reg];
        rest_nz = 1'b0;
        sticky  = 1'b0;
        for (int i = 0; i < i2d_pkg::NUM_DIGITS; i++) begin
            if ((i >= int'(keep_reg)) && (dig_reg[i] != i2d_pkg::DIGIT_ZERO)) begin
                rest_nz = 1'b1;
            end
            if ((i > int'(ptr_reg)) && (dig_reg[i] != i2d_pkg::DIGIT_ZERO)) begin
                sticky = 1'b1;
            end
            packed_bcd[(i2d_pkg::NUM_DIGITS-1-i)*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W] =
                dig_reg[i];
        end
    end

    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        cnt_next     = cnt_reg;
        bcd_next     = bcd_reg;
        dig_next     = dig_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        ptr_next     = ptr_reg;
        up_next      = up_reg;
        half_next    = half_reg;
        keep_next    = keep_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (cfg_we) begin
            keep_next = cfg_wdata;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            i2d_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    mag_next   = raw[VALUE_WIDTH-1] ? ({VALUE_WIDTH{1'b0}} - raw) : raw;
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(VALUE_WIDTH);
                    state_next = i2d_pkg::ST_CONV;
                end
            end
            i2d_pkg::ST_CONV: begin
                bcd_next = bcd_step;
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = i2d_pkg::ST_LOAD;
                end
            end
            i2d_pkg::ST_LOAD: begin
                for (int i = 0; i < i2d_pkg::NUM_DIGITS; i++) begin
                    dig_next[i] = bcd_reg[(i2d_pkg::NUM_DIGITS-1-i)*i2d_pkg::DIGIT_W
                                          +: i2d_pkg::DIGIT_W];
                end
                len_next   = i2d_pkg::FULL_LEN;
                state_next = i2d_pkg::ST_NORM;
            end
            i2d_pkg::ST_NORM: begin
                if ((dig_reg[0] == i2d_pkg::DIGIT_ZERO) && (len_reg > i2d_pkg::index_t'(1))) begin
                    for (int i = 0; i < i2d_pkg::NUM_DIGITS - 1; i++) begin
                        dig_next[i] = dig_reg[i+1];
                    end
                    dig_next[i2d_pkg::NUM_DIGITS-1] = i2d_pkg::DIGIT_ZERO;
                    len_next = len_reg - 1'b1;
                end else begin
                    pos_next = len_reg;
                    if ((keep_reg != '0) && rest_nz) begin
                        ptr_next   = keep_reg;
                        state_next = i2d_pkg::ST_DEC1;
                    end else begin
                        ptr_next   = len_reg - 1'b1;
                        state_next = i2d_pkg::ST_TRIM;
                    end
                end
            end
            i2d_pkg::ST_DEC1: begin
                up_next   = (rd > i2d_pkg::DIGIT_FIVE) || ((rd == i2d_pkg::DIGIT_FIVE) && sticky);
                half_next = (rd == i2d_pkg::DIGIT_FIVE) && !sticky;
                for (int i = 0; i < i2d_pkg::NUM_DIGITS; i++) begin
                    if (i >= int'(ptr_reg)) begin
                        dig_next[i] = i2d_pkg::DIGIT_ZERO;
                    end
                end
                ptr_next   = ptr_reg - 1'b1;
                state_next = i2d_pkg::ST_DEC2;
            end
            i2d_pkg::ST_DEC2: begin
                if (up_reg || (half_reg && rd[0])) begin
                    state_next = i2d_pkg::ST_INC;
                end else begin
                    state_next = i2d_pkg::ST_TRIM;
                end
            end
            i2d_pkg::ST_INC: begin
                if (rd < i2d_pkg::DIGIT_NINE) begin
                    dig_next[ptr_reg] = rd + i2d_pkg::DIGIT_ONE;
                    state_next        = i2d_pkg::ST_DONE;
                end else begin
                    dig_next[ptr_reg] = i2d_pkg::DIGIT_ZERO;
                    if (ptr_reg == '0) begin
                        dig_next[0] = i2d_pkg::DIGIT_ONE;
                        pos_next    = pos_reg + 1'b1;
                        state_next  = i2d_pkg::ST_DONE;
                    end else begin
                        ptr_next = ptr_reg - 1'b1;
                    end
                end
            end
            i2d_pkg::ST_TRIM: begin
                if ((ptr_reg != '0) && (rd == i2d_pkg::DIGIT_ZERO)) begin
                    ptr_next = ptr_reg - 1'b1;
                end else begin
                    state_next = i2d_pkg::ST_DONE;
                end
            end
            i2d_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {pos_reg, ptr_reg + 1'b1, packed_bcd};
                    state_next   = i2d_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = i2d_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= i2d_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            keep_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            keep_reg    <= keep_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        cnt_reg    <= cnt_next;
        bcd_reg    <= bcd_next;
        dig_reg    <= dig_next;
        len_reg    <= len_next;
        pos_reg    <= pos_next;
        ptr_reg    <= ptr_next;
        up_reg     <= up_next;
        half_reg   <= half_next;
        m_data_reg <= m_data_next;
    end

endmodule

### design/i2d_checker.sv
// Port-level checker for the binary to decimal digit converter, with its bind.
// Depends on i2d_pkg and the top level int_to_decimal_digits_round_half_even_unit.
module i2d_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [i2d_pkg::DATA_OUT_W-1:0] m_tdata
);

    logic [3:0] count;
    logic [3:0] pos;
    logic [3:0] top;

    assign count = m_tdata[43:40];
    assign pos   = m_tdata[47:44];
    assign top   = m_tdata[39:36];

    // A held result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The converter takes one request at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // The digit count is in range and never exceeds the position.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (count != 4'd0) && (count <= 4'd10) && (pos >= count) && (pos <= 4'd10))
        else $error("digit count or position out of range");

    // A leading zero digit only appears for the zero result.
    a_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (top == 4'd0) |-> (count == 4'd1) && (pos == 4'd1))
        else $error("leading zero digit in a nonzero result");

endmodule

bind int_to_decimal_digits_round_half_even_unit i2d_checker u_i2d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/testbench.sv
// Self-checking bench for int_to_decimal_digits_round_half_even_unit.
// Walks a table of directed requests and then random ones, and checks each result against
// its row's typed result or a local digit predictor; depends on i2d_pkg and the unit itself.
module testbench;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 160;

    typedef struct packed {
        i2d_pkg::index_t           pos;
        i2d_pkg::index_t           count;
        logic [i2d_pkg::BCD_W-1:0] bcd;
    } dec_result_t;

    typedef struct {
        i2d_pkg::index_t               keep;
        logic [i2d_pkg::DATA_IN_W-1:0] value;
        bit                            typed;
        dec_result_t                   want;
    } directed_row_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [i2d_pkg::KEEP_W-1:0]     cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [i2d_pkg::DATA_IN_W-1:0]  s_tdata   = '0;   // value
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [i2d_pkg::DATA_OUT_W-1:0] m_tdata;          // digits_bcd, digit_count, decimal_position

    dec_result_t     expected_results[$];
    i2d_pkg::index_t keep_digits = '0;
    int              mismatch_count = 0;
    int              burst_left = 0;
    logic [31:0]     rx_cycle = '0;
    int              hold_left = 0;
    dec_result_t     got_result;
    dec_result_t     want_result;

    directed_row_t directed_rows[] = '{
        '{4'd0,  32'd0,          1'b1, '{4'd1,  4'd1,  40'h0000000000}},
        '{4'd0,  32'd1,          1'b1, '{4'd1,  4'd1,  40'h1000000000}},
        '{4'd0,  32'hFFFFFFFF,   1'b1, '{4'd1,  4'd1,  40'h1000000000}},
        '{4'd0,  32'h7FFFFFFF,   1'b1, '{4'd10, 4'd10, 40'h2147483647}},
        '{4'd0,  32'h80000000,   1'b1, '{4'd10, 4'd10, 40'h2147483648}},
        '{4'd0,  32'd1000000000, 1'b1, '{4'd10, 4'd1,  40'h1000000000}},
        '{4'd0,  32'd120,        1'b0, '0},
        '{4'd3,  32'd12345,      1'b0, '0},
        '{4'd3,  32'd12350,      1'b0, '0},
        '{4'd3,  32'd12250,      1'b0, '0},
        '{4'd3,  32'd12251,      1'b0, '0},
        '{4'd3,  32'd99950,      1'b0, '0},
        '{4'd2,  32'd1950,       1'b0, '0},
        '{4'd2,  32'd1999,       1'b0, '0},
        '{4'd1,  32'd5,          1'b0, '0},
        '{4'd1,  32'd15,         1'b0, '0},
        '{4'd1,  32'd25,         1'b0, '0},
        '{4'd1,  32'd95,         1'b0, '0},
        '{4'd1,  32'h80000000,   1'b0, '0},
        '{4'd9,  32'h7FFFFFFF,   1'b0, '0},
        '{4'd9,  32'd1999999999, 1'b0, '0},
        '{4'd9,  32'd999999999,  1'b0, '0},
        '{4'd10, 32'h7FFFFFFF,   1'b0, '0},
        '{4'd15, 32'd1234567891, 1'b0, '0}
    };

    int unsigned phase_keep[] = '{0, 1, 2, 5, 9, 10, 15, 16};

    int_to_decimal_digits_round_half_even_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic dec_result_t predict_digits(
        input logic [i2d_pkg::DATA_IN_W-1:0] value,
        input i2d_pkg::index_t keep_cfg);
        logic [32:0]     mag;
        i2d_pkg::digit_t rev [i2d_pkg::NUM_DIGITS];
        i2d_pkg::digit_t dig [i2d_pkg::NUM_DIGITS];
        int              len;
        int              count;
        int              pos;
        int              keep;
        int              k;
        bit              up;
        dec_result_t     r;
        mag = value[31] ? (33'h1_0000_0000 - {1'b0, value}) : {1'b0, value};
        for (int i = 0; i < i2d_pkg::NUM_DIGITS; i++) begin
            rev[i] = i2d_pkg::DIGIT_ZERO;
            dig[i] = i2d_pkg::DIGIT_ZERO;
        end
        len = 0;
        do begin
            rev[len] = i2d_pkg::digit_t'(mag % 10);
            mag = mag / 10;
            len++;
        end while (mag != 0 && len < i2d_pkg::NUM_DIGITS);
        for (int i = 0; i < len; i++) begin
            dig[i] = rev[len - 1 - i];
        end
        count = len;
        pos = len;
        while (count > 1 && dig[count - 1] == i2d_pkg::DIGIT_ZERO) count--;
        keep = int'(keep_cfg);
        if (keep > 0 && keep < count) begin
            up = 1'b0;
            if (dig[keep] > i2d_pkg::DIGIT_FIVE) begin
                up = 1'b1;
            end else if (dig[keep] == i2d_pkg::DIGIT_FIVE) begin
                for (int i = keep + 1; i < count; i++) begin
                    if (dig[i] != i2d_pkg::DIGIT_ZERO) up = 1'b1;
                end
                if (!up) up = dig[keep - 1][0];
            end
            if (up) begin
                k = keep - 1;
                while (k >= 0 && dig[k] == i2d_pkg::DIGIT_NINE) begin
                    dig[k] = i2d_pkg::DIGIT_ZERO;
                    k--;
                end
                if (k < 0) begin
                    dig[0] = i2d_pkg::DIGIT_ONE;
                    pos++;
                    k = 0;
                end else begin
                    dig[k] = dig[k] + i2d_pkg::DIGIT_ONE;
                end
                keep = k + 1;
            end
            count = keep;
            while (count > 1 && dig[count - 1] == i2d_pkg::DIGIT_ZERO) count--;
        end
        r.bcd = '0;
        for (int i = 0; i < count; i++) begin
            r.bcd[i2d_pkg::BCD_W - 1 - i2d_pkg::DIGIT_W * i -: i2d_pkg::DIGIT_W] = dig[i];
        end
        r.count = i2d_pkg::index_t'(count);
        r.pos = i2d_pkg::index_t'(pos);
        return r;
    endfunction

    // Numbers are mostly built digit by digit, biased toward 0, 5 and 9,
    // so that ties and long carries come up often.
    function automatic logic [i2d_pkg::DATA_IN_W-1:0] random_value();
        logic [63:0] m;
        int          n;
        int          d;
        bit          neg;
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3: begin
                m = 64'($urandom_range(0, 1000));
            end
            default: begin
                n = $urandom_range(1, i2d_pkg::NUM_DIGITS);
                m = '0;
                for (int i = 0; i < n; i++) begin
                    if (i == 0 && n == i2d_pkg::NUM_DIGITS) begin
                        d = $urandom_range(1, 2);
                    end else begin
                        case ($urandom_range(0, 5))
                            0: d = 0;
                            1: d = 5;
                            2: d = 9;
                            default: d = $urandom_range(0, 9);
                        endcase
                    end
                    m = m * 10 + 64'(d);
                end
                if (m > 64'd2147483648) m = m % 64'd2147483649;
            end
        endcase
        if (m == 64'd2147483648) return 32'h80000000;
        neg = 1'($urandom_range(0, 1));
        return neg ? -m[31:0] : m[31:0];
    endfunction

    task automatic send_value(input logic [i2d_pkg::DATA_IN_W-1:0] value, input bit typed,
                              input dec_result_t want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(typed ? want : predict_digits(value, keep_digits));
    endtask

    task automatic set_keep(input i2d_pkg::index_t keep);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= keep;
        @(posedge aclk);
        cfg_we <= 1'b0;
        keep_digits = keep;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 32'd1;
            if (m_tvalid && m_tready) begin
                got_result = dec_result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.bcd !== want_result.bcd) begin
                        $display("%0t digits_bcd: expected %h actual %h",
                                 $time, want_result.bcd, got_result.bcd);
                        mismatch_count++;
                    end
                    if (got_result.count !== want_result.count) begin
                        $display("%0t digit_count: expected %0d actual %0d",
                                 $time, want_result.count, got_result.count);
                        mismatch_count++;
                    end
                    if (got_result.pos !== want_result.pos) begin
                        $display("%0t decimal_position: expected %0d actual %0d",
                                 $time, want_result.pos, got_result.pos);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left == 0 && rx_cycle % 30000 == 4000) hold_left = 600;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_cycle[10:9])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= 1'($urandom_range(0, 1));
                    2'd2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= rx_cycle[2];
                endcase
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i2d_pkg::index_t phase_setting;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            if (directed_rows[i].keep != keep_digits) set_keep(directed_rows[i].keep);
            send_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
        end
        foreach (phase_keep[p]) begin
            phase_setting = (phase_keep[p] > 15)
                          ? i2d_pkg::index_t'($urandom_range(0, 15))
                          : i2d_pkg::index_t'(phase_keep[p]);
            set_keep(phase_setting);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_value(random_value(), 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
design/i2d_pkg.sv
design/i2d_dabble_step.sv
design/int_to_decimal_digits_round_half_even_unit.sv
design/i2d_checker.sv
tb/testbench.sv
